### design/c8x_pkg.sv
// Shared types and constants for the CHIP-8 execute unit.
package c8x_pkg;
   localparam int StackDepth = 16;
   localparam int SpW = $clog2(StackDepth + 1);
   localparam int SpIdxW = $clog2(StackDepth);

   typedef enum logic [4:0] {
      CMD_RET = 5'd0, CMD_JP = 5'd1, CMD_CALL = 5'd2, CMD_SE_B = 5'd3, CMD_SNE_B = 5'd4,
      CMD_SE_R = 5'd5, CMD_LD_B = 5'd6, CMD_ADD_B = 5'd7, CMD_LD_R = 5'd8, CMD_OR = 5'd9,
      CMD_AND = 5'd10, CMD_XOR = 5'd11, CMD_ADD_R = 5'd12, CMD_SUB = 5'd13,
      CMD_SHR = 5'd14, CMD_SUBN = 5'd15, CMD_SHL = 5'd16, CMD_SNE_R = 5'd17,
      CMD_LD_I = 5'd18, CMD_JP_V0 = 5'd19, CMD_RND = 5'd20, CMD_SKP = 5'd21,
      CMD_SKNP = 5'd22, CMD_LD_VDT = 5'd23, CMD_LD_DT = 5'd24, CMD_LD_ST = 5'd25,
      CMD_ADD_I = 5'd26, CMD_LD_BCD = 5'd27, CMD_ST_REGS = 5'd28
   } cmd_type;

   typedef struct packed {
      logic [4:0]  cmd;
      logic [3:0]  reg_x;
      logic [3:0]  reg_y;
      logic [7:0]  imm_byte;
      logic [11:0] target_addr;
      logic [7:0]  random_byte;
      logic [15:0] keys_down;
   } req_type;

   typedef struct packed {
      logic [11:0] new_pc;
      logic        mem_write;
      logic [11:0] mem_addr;
      logic [7:0]  mem_data;
      logic        stack_error;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_RUN, ST_BCD} state_type;

   function automatic logic [11:0] to_bcd(input logic [7:0] v);
      logic [19:0] s;
      s = {12'd0, v};
      for (int i = 0; i < 8; i++) begin
         for (int p = 0; p < 3; p++) begin
            if (s[8 + 4*p +: 4] >= 4'd5) s[8 + 4*p +: 4] = s[8 + 4*p +: 4] + 4'd3;
         end
         s = s << 1;
      end
      return s[19:8];
   endfunction
endpackage

### design/c8x_req_if.sv
// Valid/ready channel carrying one decoded instruction.
interface c8x_req_if;
   import c8x_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### design/c8x_rsp_if.sv
// Valid/ready channel carrying one result.
interface c8x_rsp_if;
   import c8x_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### design/c8x_front.sv
// Front end: two-entry instruction queue.
module c8x_front (
   input logic clock,
   input logic reset,
   c8x_req_if.sink req,
   input logic pop,
   output logic q_valid,
   output c8x_pkg::req_type q_item
);
   import c8x_pkg::*;
   req_type mem_ff [2];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = mem_ff[rd_ff];
   assign rd_in = pop ? ~rd_ff : rd_ff;
   assign wr_in = push ? ~wr_ff : wr_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= req.payload;
   end
endmodule

### design/c8x_back.sv
// Back end: register file, stack, timers and result sequencing.
module c8x_back (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input c8x_pkg::req_type q_item,
   output logic pop,
   c8x_rsp_if.source rsp
);
   import c8x_pkg::*;
   state_type state_ff, state_in;
   logic [7:0] v_ff [16];
   logic [15:0] i_ff, i_in;
   logic [11:0] pc_ff, pc_in;
   logic [11:0] stk_ff [StackDepth];
   logic [SpW-1:0] sp_ff, sp_in;
   logic [7:0] dt_ff, dt_in, st_ff, st_in;
   req_type cur_ff;
   logic [3:0] cnt_ff, cnt_in;
   logic [11:0] bcd_ff, bcd_in;
   logic ov_ff, ov_in;
   rsp_type out_ff, out_in;
   logic vwr, fwr, push_stk, take;
   logic [7:0] vval, fval, vx, vy;
   logic [8:0] sum;
   logic skip;

   assign rsp.valid = ov_ff;
   assign rsp.payload = out_ff;
   assign take = !ov_ff || rsp.ready;
   assign vx = v_ff[cur_ff.reg_x];
   assign vy = v_ff[cur_ff.reg_y];

   always_comb begin
      state_in = state_ff;
      i_in = i_ff; pc_in = pc_ff; sp_in = sp_ff; dt_in = dt_ff; st_in = st_ff;
      cnt_in = cnt_ff; bcd_in = bcd_ff;
      ov_in = ov_ff && !rsp.ready;
      out_in = out_ff;
      vwr = 1'b0; fwr = 1'b0; vval = 8'd0; fval = 8'd0; push_stk = 1'b0;
      skip = 1'b0; sum = 9'd0; pop = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (take) begin
               out_in = '{new_pc: pc_ff, mem_write: 1'b0, mem_addr: 12'd0,
                          mem_data: 8'd0, stack_error: 1'b0, last: 1'b1};
               ov_in = 1'b1;
               state_in = ST_IDLE;
               case (cur_ff.cmd)
                  CMD_RET: begin
                     if (sp_ff == '0) out_in.stack_error = 1'b1;
                     else begin
                        sp_in = sp_ff - 1'b1;
                        pc_in = stk_ff[sp_in[SpIdxW-1:0]];
                     end
                  end
                  CMD_JP: pc_in = cur_ff.target_addr;
                  CMD_CALL: begin
                     if (sp_ff >= SpW'(StackDepth)) out_in.stack_error = 1'b1;
                     else begin
                        push_stk = 1'b1;
                        sp_in = sp_ff + 1'b1;
                        pc_in = cur_ff.target_addr;
                     end
                  end
                  CMD_SE_B: skip = (vx == cur_ff.imm_byte);
                  CMD_SNE_B: skip = (vx != cur_ff.imm_byte);
                  CMD_SE_R: skip = (vx == vy);
                  CMD_SNE_R: skip = (vx != vy);
                  CMD_LD_B: begin vwr = 1'b1; vval = cur_ff.imm_byte; end
                  CMD_ADD_B: begin vwr = 1'b1; vval = vx + cur_ff.imm_byte; end
                  CMD_LD_R: begin vwr = 1'b1; vval = vy; end
                  CMD_OR: begin vwr = 1'b1; vval = vx | vy; end
                  CMD_AND: begin vwr = 1'b1; vval = vx & vy; end
                  CMD_XOR: begin vwr = 1'b1; vval = vx ^ vy; end
                  CMD_ADD_R: begin
                     sum = {1'b0, vx} + {1'b0, vy};
                     vwr = 1'b1; vval = sum[7:0]; fwr = 1'b1; fval = {7'd0, sum[8]};
                  end
                  CMD_SUB: begin
                     vwr = 1'b1; vval = vx - vy; fwr = 1'b1; fval = {7'd0, vx >= vy};
                  end
                  CMD_SHR: begin
                     vwr = 1'b1; vval = vx >> 1; fwr = 1'b1; fval = {7'd0, vx[0]};
                  end
                  CMD_SUBN: begin
                     vwr = 1'b1; vval = vy - vx; fwr = 1'b1; fval = {7'd0, vy >= vx};
                  end
                  CMD_SHL: begin
                     vwr = 1'b1; vval = vx << 1; fwr = 1'b1; fval = {7'd0, vx[7]};
                  end
                  CMD_LD_I: i_in = {4'd0, cur_ff.target_addr};
                  CMD_JP_V0: pc_in = cur_ff.target_addr + {4'd0, v_ff[0]};
                  CMD_RND: begin vwr = 1'b1; vval = cur_ff.random_byte & cur_ff.imm_byte; end
                  CMD_SKP: skip = cur_ff.keys_down[vx[3:0]];
                  CMD_SKNP: skip = !cur_ff.keys_down[vx[3:0]];
                  CMD_LD_VDT: begin vwr = 1'b1; vval = dt_ff; end
                  CMD_LD_DT: dt_in = vx;
                  CMD_LD_ST: st_in = vx;
                  CMD_ADD_I: i_in = i_ff + {8'd0, vx};
                  CMD_LD_BCD: begin
                     bcd_in = to_bcd(vx);
                     ov_in = ov_ff && !rsp.ready;
                     cnt_in = 4'd0;
                     state_in = ST_BCD;
                  end
                  CMD_ST_REGS: begin
                     ov_in = ov_ff && !rsp.ready;
                     cnt_in = 4'd0;
                     state_in = ST_RUN;
                  end
                  default: ;
               endcase
               if (skip) pc_in = pc_ff + 12'd2;
               out_in.new_pc = pc_in;
            end
         end
         ST_BCD: begin
            if (take) begin
               out_in = '{new_pc: pc_ff, mem_write: 1'b1,
                          mem_addr: i_ff[11:0] + {8'd0, cnt_ff},
                          mem_data: {4'd0, bcd_ff[11:8]}, stack_error: 1'b0,
                          last: cnt_ff == 4'd2};
               ov_in = 1'b1;
               bcd_in = bcd_ff << 4;
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd2) state_in = ST_IDLE;
            end
         end
         ST_RUN: begin
            if (take) begin
               out_in = '{new_pc: pc_ff, mem_write: 1'b1,
                          mem_addr: i_ff[11:0] + {8'd0, cnt_ff},
                          mem_data: v_ff[cnt_ff], stack_error: 1'b0,
                          last: cnt_ff == cur_ff.reg_x};
               ov_in = 1'b1;
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == cur_ff.reg_x) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff <= 16'd0;
         pc_ff <= 12'd512;
         sp_ff <= '0;
         dt_ff <= 8'd0;
         st_ff <= 8'd0;
         ov_ff <= 1'b0;
         for (int k = 0; k < 16; k++) v_ff[k] <= 8'd0;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
         pc_ff <= pc_in;
         sp_ff <= sp_in;
         dt_ff <= dt_in;
         st_ff <= st_in;
         ov_ff <= ov_in;
         if (vwr && !(fwr && cur_ff.reg_x == 4'd15)) v_ff[cur_ff.reg_x] <= vval;
         if (fwr) v_ff[15] <= fval;
      end
      if (pop) cur_ff <= q_item;
      if (push_stk) stk_ff[sp_ff[SpIdxW-1:0]] <= pc_ff;
      cnt_ff <= cnt_in;
      bcd_ff <= bcd_in;
      out_ff <= out_in;
   end
endmodule

### design/chip8_instruction_execute_unit.sv
// Top level of the CHIP-8 execute unit.
// Most items give one result; a BCD store gives three, a block store x+1.
// The back end runs one instruction at a time; a two-entry queue feeds it.
// Synchronous reset: V registers, I and timers to zero, PC to 512, stack empty.
module chip8_instruction_execute_unit (
   input logic clock,
   input logic reset,
   c8x_req_if.sink req,
   c8x_rsp_if.source rsp
);
   import c8x_pkg::*;
   logic q_valid, pop;
   req_type q_item;

   c8x_front u_front (.clock, .reset, .req, .pop, .q_valid, .q_item);
   c8x_back u_back (.clock, .reset, .q_valid, .q_item, .pop, .rsp);
endmodule

### design/c8x_checker.sv
// Port-level checks for the CHIP-8 execute unit, bound to the top level.
module c8x_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input c8x_pkg::rsp_type rsp_payload
);
   import c8x_pkg::*;
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped while stalled");
   a_nowr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.mem_write |-> rsp_payload.mem_addr == 12'd0 &&
      rsp_payload.mem_data == 8'd0 && rsp_payload.last)
      else $error("non-write result malformed");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.stack_error |-> !rsp_payload.mem_write)
      else $error("stack error on write");
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule

bind chip8_instruction_execute_unit c8x_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload));
